// ----- design/kstr_pkg.sv -----
// shared types, codes and constants of the key state and typematic repeat block
package kstr_pkg;

   // key table geometry
   localparam int KEY_W    = 7;
   localparam int KEY_SPAN = 1 << KEY_W;
   localparam int NUM_KEYS = 128;

   // field widths
   localparam int CMD_W       = 2;
   localparam int KIND_W      = 2;
   localparam int CNT_W       = 16;
   localparam int CSR_INDEX_W = 2;

   // commands
   localparam logic [CMD_W-1:0] CMD_KEY_EVENT = 2'd0;
   localparam logic [CMD_W-1:0] CMD_TICK      = 2'd1;
   localparam logic [CMD_W-1:0] CMD_QUERY     = 2'd2;
   localparam logic [CMD_W-1:0] CMD_NONE      = 2'd3;

   // result kinds
   localparam logic [KIND_W-1:0] KIND_REPORT = 2'd0;
   localparam logic [KIND_W-1:0] KIND_REPEAT = 2'd1;
   localparam logic [KIND_W-1:0] KIND_QUERY  = 2'd2;

   // lock keys
   localparam logic [KEY_W-1:0] KEY_CAPS_LOCK   = 7'h3A;
   localparam logic [KEY_W-1:0] KEY_NUM_LOCK    = 7'h45;
   localparam logic [KEY_W-1:0] KEY_SCROLL_LOCK = 7'h46;

   // register indexes and reset values
   localparam logic [CSR_INDEX_W-1:0] CSR_DELAY   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_RATE    = 2'd1;
   localparam logic [CNT_W-1:0]       DELAY_RESET = 16'd30;
   localparam logic [CNT_W-1:0]       RATE_RESET  = 16'd3;

   typedef struct packed {
      logic [CMD_W-1:0] command;
      logic [KEY_W-1:0] scancode;
      logic             released;
   } req_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [KEY_W-1:0]  key_code;
      logic              key_down;
      logic              lock_toggled;
   } rsp_type;

   // one key table entry
   typedef struct packed {
      logic down;
      logic toggle;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   function automatic logic key_in_range(input logic [KEY_W-1:0] k);
      key_in_range = ({1'b0, k} < (KEY_W + 1)'(NUM_KEYS));
   endfunction

   function automatic logic is_lock_key(input logic [KEY_W-1:0] k);
      is_lock_key = (k == KEY_CAPS_LOCK) || (k == KEY_NUM_LOCK) || (k == KEY_SCROLL_LOCK);
   endfunction

endpackage

// ----- design/kstr_ram.sv -----
// generic single-write, single-read ram with registered read data
module kstr_ram #(
   parameter int WIDTH = 2,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read port, old data on a same-address write
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/key_state_and_typematic_repeat.sv -----
// top level: key down/toggle tables, typematic repeat timer and result register
//
// Usage:
//   req_* carries key events, timer ticks and key state queries; an item is
//   taken at a clock edge with req_valid high and req_stall low.
//   rsp_* carries state reports, generated repeat presses and query answers;
//   a result leaves at an edge with rsp_valid high and rsp_stall low.
//   csr_* writes the repeat delay (index 0) and repeat rate (index 1);
//   csr_ready is always high. Write only while no item is in flight.
// Timing:
//   one item per cycle sustained while no stall holds the output. The key
//   table ram read happens at the same edge that loads the input register,
//   and the update goes into the result register once the output register
//   can advance. Ignored items give no result; ticks give one only when a
//   repeat press is due.
// Reset (synchronous, active high):
//   all keys read as up and untoggled at once (per-key valid flops), repeat
//   disarmed, registers back to delay 30 and rate 3. No clearing pass.
// Stall:
//   a stalled result holds in the output register while the next item waits
//   in the input stage; only then is req_stall raised.
module key_state_and_typematic_repeat (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  kstr_pkg::req_type                      req_data,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output kstr_pkg::rsp_type                      rsp_data,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [kstr_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [kstr_pkg::CNT_W-1:0]             csr_data
);

   import kstr_pkg::*;

   // stage registers
   logic              s1_valid_ff, s1_valid_in;
   req_type           s1_data_ff, s1_data_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;

   // repeat state and configuration
   logic [KEY_W-1:0]  repeat_key_ff, repeat_key_in;
   logic              repeat_armed_ff, repeat_armed_in;
   logic [CNT_W-1:0]  hold_count_ff, hold_count_in;
   logic [CNT_W-1:0]  repeat_phase_ff, repeat_phase_in;
   logic [CNT_W-1:0]  delay_cfg_ff, delay_cfg_in;
   logic [CNT_W-1:0]  rate_cfg_ff, rate_cfg_in;

   // key table bookkeeping
   logic [KEY_SPAN-1:0] key_valid_ff, key_valid_in;
   logic                fwd_valid_ff, fwd_valid_in;
   logic [KEY_W-1:0]    fwd_key_ff, fwd_key_in;
   entry_type           fwd_entry_ff, fwd_entry_in;

   logic              advance;
   logic              process;
   logic              req_accept;
   logic [KEY_W-1:0]  rd_addr;
   entry_type         ram_q;
   logic [KEY_W-1:0]  look_key;
   entry_type         cur_entry;
   entry_type         new_entry;
   logic              wr_en;
   logic              has_result;
   logic              look_ok;
   logic [CNT_W-1:0]  hold_inc;
   logic [CNT_W-1:0]  phase_inc;

   // handshake
   assign advance    = !rsp_valid_ff || !rsp_stall;
   assign process    = s1_valid_ff && advance;
   assign req_stall  = s1_valid_ff && !advance;
   assign req_accept = req_valid && !req_stall;
   assign csr_ready  = 1'b1;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   // table read: a tick reads the key that will be repeating when it arrives
   assign rd_addr = (req_data.command == CMD_TICK) ? repeat_key_in : req_data.scancode;

   kstr_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (KEY_SPAN)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (s1_data_ff.scancode),
      .wr_data (new_entry),
      .rd_en   (req_accept),
      .rd_addr (rd_addr),
      .rd_data (ram_q)
   );

   // current entry: latest write wins, never-written keys read as zero
   assign look_key = (s1_data_ff.command == CMD_TICK) ? repeat_key_ff : s1_data_ff.scancode;
   assign look_ok  = key_in_range(look_key);

   always_comb begin
      if (fwd_valid_ff && (fwd_key_ff == look_key)) begin
         cur_entry = fwd_entry_ff;
      end else if (key_valid_ff[look_key]) begin
         cur_entry = ram_q;
      end else begin
         cur_entry = '0;
      end
   end

   assign hold_inc  = hold_count_ff + 1'b1;
   assign phase_inc = repeat_phase_ff + 1'b1;

   // item processing
   always_comb begin
      repeat_key_in   = repeat_key_ff;
      repeat_armed_in = repeat_armed_ff;
      hold_count_in   = hold_count_ff;
      repeat_phase_in = repeat_phase_ff;
      new_entry       = cur_entry;
      wr_en           = 1'b0;
      has_result      = 1'b0;
      rsp_data_in     = rsp_data_ff;
      if (process) begin
         case (s1_data_ff.command)
            CMD_KEY_EVENT: begin
               if (look_ok) begin
                  wr_en = 1'b1;
                  has_result = 1'b1;
                  if (!s1_data_ff.released) begin
                     new_entry.toggle = cur_entry.toggle ^
                                        (is_lock_key(look_key) && !cur_entry.down);
                     new_entry.down   = 1'b1;
                     repeat_key_in    = look_key;
                     hold_count_in    = '0;
                     repeat_phase_in  = '0;
                     repeat_armed_in  = 1'b1;
                  end else begin
                     new_entry.down = 1'b0;
                     if (repeat_key_ff == look_key) begin
                        repeat_armed_in = 1'b0;
                     end
                  end
                  rsp_data_in.kind         = KIND_REPORT;
                  rsp_data_in.key_code     = look_key;
                  rsp_data_in.key_down     = new_entry.down;
                  rsp_data_in.lock_toggled = new_entry.toggle;
               end
            end
            CMD_TICK: begin
               if (repeat_armed_ff) begin
                  if (hold_count_ff < delay_cfg_ff) begin
                     hold_count_in = hold_inc;
                     if (hold_inc == delay_cfg_ff) begin
                        repeat_phase_in = '0;
                        has_result      = 1'b1;
                     end
                  end else if (phase_inc >= rate_cfg_ff) begin
                     repeat_phase_in = '0;
                     has_result      = 1'b1;
                  end else begin
                     repeat_phase_in = phase_inc;
                  end
               end
               rsp_data_in.kind         = KIND_REPEAT;
               rsp_data_in.key_code     = look_key;
               rsp_data_in.key_down     = look_ok && cur_entry.down;
               rsp_data_in.lock_toggled = look_ok && cur_entry.toggle;
            end
            CMD_QUERY: begin
               has_result               = 1'b1;
               rsp_data_in.kind         = KIND_QUERY;
               rsp_data_in.key_code     = look_key;
               rsp_data_in.key_down     = look_ok && cur_entry.down;
               rsp_data_in.lock_toggled = look_ok && cur_entry.toggle;
            end
            default: begin
               has_result = 1'b0;
            end
         endcase
      end
   end

   // stage and output control
   always_comb begin
      s1_data_in  = req_accept ? req_data : s1_data_ff;
      s1_valid_in = req_accept ? 1'b1 : (advance ? 1'b0 : s1_valid_ff);
      rsp_valid_in = advance ? (s1_valid_ff && has_result) : rsp_valid_ff;
   end

   // table bookkeeping: valid flop per key and last-write bypass
   always_comb begin
      key_valid_in = key_valid_ff;
      fwd_valid_in = fwd_valid_ff;
      fwd_key_in   = fwd_key_ff;
      fwd_entry_in = fwd_entry_ff;
      if (wr_en) begin
         key_valid_in[look_key] = 1'b1;
         fwd_valid_in           = 1'b1;
         fwd_key_in             = look_key;
         fwd_entry_in           = new_entry;
      end
   end

   // configuration writes
   always_comb begin
      delay_cfg_in = delay_cfg_ff;
      rate_cfg_in  = rate_cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_DELAY: delay_cfg_in = csr_data;
            CSR_RATE:  rate_cfg_in  = csr_data;
            default: begin
               delay_cfg_in = delay_cfg_ff;
            end
         endcase
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         repeat_key_ff   <= '0;
         repeat_armed_ff <= 1'b0;
         hold_count_ff   <= '0;
         repeat_phase_ff <= '0;
         delay_cfg_ff    <= DELAY_RESET;
         rate_cfg_ff     <= RATE_RESET;
         key_valid_ff    <= '0;
         fwd_valid_ff    <= 1'b0;
      end else begin
         s1_valid_ff     <= s1_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
         repeat_key_ff   <= repeat_key_in;
         repeat_armed_ff <= repeat_armed_in;
         hold_count_ff   <= hold_count_in;
         repeat_phase_ff <= repeat_phase_in;
         delay_cfg_ff    <= delay_cfg_in;
         rate_cfg_ff     <= rate_cfg_in;
         key_valid_ff    <= key_valid_in;
         fwd_valid_ff    <= fwd_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      s1_data_ff   <= s1_data_in;
      rsp_data_ff  <= rsp_data_in;
      fwd_key_ff   <= fwd_key_in;
      fwd_entry_ff <= fwd_entry_in;
   end

   // the bypass entry always belongs to a key marked as written
   assert property (@(posedge clock) disable iff (reset)
      fwd_valid_ff |-> key_valid_ff[fwd_key_ff])
      else $error("bypass entry for a key never written");

   // input is held back only while the input stage is occupied
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid_ff)
      else $error("stall raised with empty input stage");

   // a taken result with nothing behind it leaves the output empty
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_stall && !s1_valid_ff) |=> !rsp_valid_ff)
      else $error("result repeated after transfer");

   // the hold count only steps by one or restarts
   assert property (@(posedge clock) disable iff (reset)
      (hold_count_ff != $past(hold_count_ff)) |->
         ((hold_count_ff == $past(hold_count_ff) + 1'b1) || (hold_count_ff == '0)))
      else $error("hold count jumped");

endmodule

// ----- tb/key_state_and_typematic_repeat_test.sv -----
// testbench for the key state tables with typematic repeat and lock toggles
`timescale 1ns / 1ps

module key_state_and_typematic_repeat_test;
   import kstr_pkg::*;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int PHASE_ITEMS  = 320;
   localparam int DRAIN_CYCLES = 4;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                   req_valid = 1'b0;
   logic                   req_stall;
   req_type                req_data  = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   rsp_type                rsp_data;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_DELAY;
   logic [CNT_W-1:0]       csr_data  = '0;

   // shadow of the key tables, the repeat timer and the registers
   bit               down_tbl [NUM_KEYS];
   bit               toggle_tbl [NUM_KEYS];
   logic [KEY_W-1:0] held_key;
   bit               held_armed;
   logic [CNT_W-1:0] hold_ticks;
   logic [CNT_W-1:0] phase_ticks;
   logic [CNT_W-1:0] delay_reg;
   logic [CNT_W-1:0] rate_reg;

   rsp_type key_reports_due [$];

   int  mismatch_count  = 0;
   int  effective_items = 0;
   int  cycle_count     = 0;
   int  sent_count      = 0;
   int  taken_count     = 0;
   int  rsp_hold        = 0;
   bit  send_gaps       = 1'b1;
   bit  recv_gaps       = 1'b1;

   key_state_and_typematic_repeat dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // 8 ns clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, key_reports_due.size());
         $display("FAIL key_state_and_typematic_repeat");
         $finish;
      end
   end

   task automatic report_mismatch(input string msg);
      if (mismatch_count < 40)
         $display("[%0t] mismatch: %s", $time, msg);
      mismatch_count++;
   endtask

   // queue the state report of one key as it stands now
   function automatic void queue_key_report(input logic [KIND_W-1:0] kind,
                                            input logic [KEY_W-1:0] code);
      rsp_type r;
      bit      in_table;
      in_table       = int'(code) < NUM_KEYS;
      r.kind         = kind;
      r.key_code     = code;
      r.key_down     = in_table ? down_tbl[code] : 1'b0;
      r.lock_toggled = in_table ? toggle_tbl[code] : 1'b0;
      key_reports_due.push_back(r);
   endfunction

   function automatic void clear_key_state();
      foreach (down_tbl[i]) begin
         down_tbl[i]   = 1'b0;
         toggle_tbl[i] = 1'b0;
      end
      held_key    = '0;
      held_armed  = 1'b0;
      hold_ticks  = '0;
      phase_ticks = '0;
      delay_reg   = DELAY_RESET;
      rate_reg    = RATE_RESET;
   endfunction

   // advance the key tables and the repeat timer by one accepted item
   function automatic void apply_key_item(input req_type item);
      logic [KEY_W-1:0] code;
      code = item.scancode;
      case (item.command)
         CMD_KEY_EVENT: begin
            if (int'(code) < NUM_KEYS) begin
               effective_items++;
               if (!item.released) begin
                  // lock keys flip only on a fresh press
                  if ((code == KEY_CAPS_LOCK || code == KEY_NUM_LOCK ||
                       code == KEY_SCROLL_LOCK) && !down_tbl[code])
                     toggle_tbl[code] = ~toggle_tbl[code];
                  down_tbl[code] = 1'b1;
                  held_key    = code;
                  hold_ticks  = '0;
                  phase_ticks = '0;
                  held_armed  = 1'b1;
               end else begin
                  down_tbl[code] = 1'b0;
                  if (held_key == code)
                     held_armed = 1'b0;
               end
               queue_key_report(KIND_REPORT, code);
            end
         end
         CMD_TICK: begin
            if (held_armed) begin
               effective_items++;
               if (hold_ticks < delay_reg) begin
                  hold_ticks++;
                  if (hold_ticks == delay_reg) begin
                     phase_ticks = '0;
                     queue_key_report(KIND_REPEAT, held_key);
                  end
               end else begin
                  phase_ticks++;
                  if (phase_ticks >= rate_reg) begin
                     phase_ticks = '0;
                     queue_key_report(KIND_REPEAT, held_key);
                  end
               end
            end
         end
         CMD_QUERY: begin
            effective_items++;
            queue_key_report(KIND_QUERY, code);
         end
         default: ;
      endcase
   endfunction

   // one input transfer, preceded by a random gap
   task automatic send_item(input logic [CMD_W-1:0] command,
                            input logic [KEY_W-1:0] code,
                            input logic             released);
      req_type item;
      int      gap;
      item.command  = command;
      item.scancode = code;
      item.released = released;
      gap = send_gaps ? $urandom_range(0, 4) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      apply_key_item(item);
      sent_count++;
      if (sent_count % 40 == 0)
         send_gaps = $urandom_range(0, 3) != 0;
   endtask

   task automatic send_ticks(input int count);
      repeat (count) send_item(CMD_TICK, '0, 1'b0);
   endtask

   // wait until every result is out and the pipeline has emptied
   task automatic wait_quiet();
      req_valid <= 1'b0;
      @(posedge clock);
      while (key_reports_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_INDEX_W-1:0] index,
                                 input logic [CNT_W-1:0]       value);
      csr_index <= index;
      csr_data  <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      if (index == CSR_DELAY)
         delay_reg = value;
      else if (index == CSR_RATE)
         rate_reg = value;
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_repeat(input logic [CNT_W-1:0] delay, input logic [CNT_W-1:0] rate);
      wait_quiet();
      write_register(CSR_DELAY, delay);
      write_register(CSR_RATE, rate);
   endtask

   // result checking and receiver stalls
   always @(posedge clock) begin : check_results
      rsp_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (key_reports_due.size() == 0) begin
               report_mismatch($sformatf("result with none awaited: kind %0d key %02h",
                                         rsp_data.kind, rsp_data.key_code));
            end else begin
               want = key_reports_due.pop_front();
               if (rsp_data.kind !== want.kind)
                  report_mismatch($sformatf("kind %0d, want %0d",
                                            rsp_data.kind, want.kind));
               if (rsp_data.key_code !== want.key_code)
                  report_mismatch($sformatf("key_code %02h, want %02h",
                                            rsp_data.key_code, want.key_code));
               if (rsp_data.key_down !== want.key_down)
                  report_mismatch($sformatf("key_down %b, want %b (key %02h)",
                                            rsp_data.key_down, want.key_down,
                                            want.key_code));
               if (rsp_data.lock_toggled !== want.lock_toggled)
                  report_mismatch($sformatf("lock_toggled %b, want %b (key %02h)",
                                            rsp_data.lock_toggled, want.lock_toggled,
                                            want.key_code));
            end
            taken_count++;
            if (taken_count % 64 == 0)
               recv_gaps = $urandom_range(0, 2) != 0;
            rsp_hold = recv_gaps ? $urandom_range(0, 4) : 0;
         end else if (rsp_valid && rsp_hold > 0) begin
            rsp_hold--;
         end
         rsp_stall <= (rsp_hold != 0);
      end
   end

   // fresh tables read as zero, unarmed ticks and the unused command do nothing
   task automatic test_reset_state();
      send_item(CMD_QUERY, 7'h00, 1'b0);
      send_item(CMD_QUERY, 7'h7F, 1'b1);
      send_item(CMD_QUERY, KEY_CAPS_LOCK, 1'b0);
      send_ticks(2);
      send_item(CMD_NONE, 7'h7F, 1'b1);
   endtask

   // lock keys flip on fresh presses only, and a key other than the held one is released
   task automatic test_lock_keys();
      send_item(CMD_KEY_EVENT, KEY_CAPS_LOCK, 1'b0);
      send_item(CMD_KEY_EVENT, KEY_CAPS_LOCK, 1'b0);
      send_item(CMD_KEY_EVENT, KEY_CAPS_LOCK, 1'b1);
      send_item(CMD_KEY_EVENT, KEY_CAPS_LOCK, 1'b0);
      send_item(CMD_KEY_EVENT, KEY_NUM_LOCK, 1'b0);
      send_item(CMD_KEY_EVENT, KEY_NUM_LOCK, 1'b1);
      send_item(CMD_KEY_EVENT, KEY_SCROLL_LOCK, 1'b0);
      send_item(CMD_KEY_EVENT, 7'h01, 1'b0);
      send_item(CMD_KEY_EVENT, 7'h7F, 1'b0);
      send_item(CMD_KEY_EVENT, 7'h01, 1'b1);
      send_item(CMD_QUERY, KEY_NUM_LOCK, 1'b0);
      send_item(CMD_QUERY, 7'h7F, 1'b0);
   endtask

   // zero delay and unit rate: a repeat press on every tick
   task automatic test_fast_repeat();
      set_repeat(16'd0, 16'd1);
      send_item(CMD_KEY_EVENT, 7'h1C, 1'b0);
      send_ticks(3);
      send_item(CMD_KEY_EVENT, 7'h1C, 1'b1);
      send_ticks(1);
   endtask

   // largest delay and rate, then lowered under the running count
   task automatic test_register_extremes();
      set_repeat(16'hFFFF, 16'd1);
      send_item(CMD_KEY_EVENT, 7'h50, 1'b0);
      send_ticks(4);
      set_repeat(16'd2, 16'd1);
      send_ticks(2);
      set_repeat(16'd0, 16'hFFFF);
      send_item(CMD_KEY_EVENT, 7'h51, 1'b0);
      send_ticks(3);
      set_repeat(16'd0, 16'd2);
      send_ticks(3);
   endtask

   function automatic logic [KEY_W-1:0] pick_key();
      int r;
      r = $urandom_range(0, 9);
      if (r < 3) begin
         case ($urandom_range(0, 2))
            0:       return KEY_CAPS_LOCK;
            1:       return KEY_NUM_LOCK;
            default: return KEY_SCROLL_LOCK;
         endcase
      end
      if (r < 6)
         return KEY_W'($urandom_range(0, 7));
      return KEY_W'($urandom_range(0, NUM_KEYS - 1));
   endfunction

   // mostly press-hold-release sequences with random content, some noise
   task automatic random_phase(input int target);
      logic [KEY_W-1:0] code;
      int               r;
      int               span;
      int               goal;
      goal = effective_items + target;
      while (effective_items < goal) begin
         r = $urandom_range(0, 9);
         if (r < 7) begin
            code = pick_key();
            send_item(CMD_KEY_EVENT, code, 1'b0);
            span = int'(delay_reg) + 3 * int'(rate_reg);
            send_ticks($urandom_range(0, span > 40 ? 40 : span));
            if ($urandom_range(0, 1))
               send_item(CMD_QUERY, $urandom_range(0, 1) ? code : pick_key(), 1'b0);
            if ($urandom_range(0, 4) != 0)
               send_item(CMD_KEY_EVENT, code, 1'b1);
         end else if (r < 9) begin
            repeat ($urandom_range(1, 4))
               send_item(CMD_W'($urandom_range(0, 3)),
                         KEY_W'($urandom_range(0, NUM_KEYS - 1)),
                         1'($urandom_range(0, 1)));
         end else begin
            repeat (3)
               send_item(CMD_KEY_EVENT, pick_key(), 1'($urandom_range(0, 1)));
         end
      end
   endtask

   task automatic test_random();
      set_repeat(16'd4, 16'd2);
      random_phase(PHASE_ITEMS);
      set_repeat(CNT_W'($urandom_range(0, 10)), CNT_W'($urandom_range(1, 5)));
      random_phase(PHASE_ITEMS);
      set_repeat(CNT_W'($urandom), CNT_W'($urandom_range(1, 65535)));
      random_phase(PHASE_ITEMS);
      set_repeat(16'd1, 16'd1);
      random_phase(PHASE_ITEMS);
      set_repeat(DELAY_RESET, RATE_RESET);
      random_phase(PHASE_ITEMS);
   endtask

   // main sequence
   initial begin
      clear_key_state();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_state();
      test_lock_keys();
      test_fast_repeat();
      test_register_extremes();
      test_random();

      wait_quiet();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (key_reports_due.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", key_reports_due.size()));
      if (mismatch_count == 0)
         $display("PASS key_state_and_typematic_repeat");
      else
         $display("FAIL key_state_and_typematic_repeat");
      $finish;
   end

endmodule

// ----- files.f -----
design/kstr_pkg.sv
design/kstr_ram.sv
design/key_state_and_typematic_repeat.sv
tb/key_state_and_typematic_repeat_test.sv
